>>> rtl/wbtc_pkg.sv
package wbtc_pkg;

	// default sizing
	localparam int TEXT_LIMIT_DEF     = 8192;
	localparam int MAX_DOC_CHUNKS_DEF = 512;
	localparam int SIZE_LIMIT_DEF     = 512;
	localparam int SPACE_WINDOW_DEF   = 1024;

	// configuration port
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 2;
	localparam int OVL_W     = 9;

	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OVERLAP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUARTER    = 2'd2;

	localparam logic [CFG_W-1:0] CHUNK_SIZE_RST = 10'd128;
	localparam logic [OVL_W-1:0] OVERLAP_RST    = 9'd32;

	localparam logic [7:0] SPACE_CODE    = 8'h20;
	localparam int         QUARTER_SHIFT = 2;

	localparam int ID_W      = 16;
	localparam int POS_OUT_W = 14;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} wbtc_in_t;

	typedef struct packed {
		logic [ID_W-1:0]      chunk_seq;
		logic [POS_OUT_W-1:0] chunk_start;
		logic [POS_OUT_W-1:0] chunk_end;
		logic                 first_in_doc;
		logic                 last_chunk;
	} wbtc_out_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic emit_mid;
		logic emit_last;
		logic set_lo;
		logic set_idx;
		logic scan_step;
	} wbtc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit_in;
		logic eot_in;
		logic eot_pend;
		logic emit_ok;
		logic scan_done;
	} wbtc_status_t;

endpackage

>>> rtl/wbtc_ram.sv
module wbtc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/wbtc_ctrl.sv
module wbtc_ctrl
	import wbtc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  wbtc_status_t status,
	output wbtc_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_EMIT_MID  = 3'd1;
	localparam logic [2:0] ST_SET_LO    = 3'd2;
	localparam logic [2:0] ST_SET_IDX   = 3'd3;
	localparam logic [2:0] ST_SCAN      = 3'd4;
	localparam logic [2:0] ST_EMIT_LAST = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.hit_in) begin
						state_d = ST_EMIT_MID;
					end else if (status.eot_in) begin
						state_d = ST_EMIT_LAST;
					end
				end
			end
			ST_EMIT_MID: begin
				if (status.emit_ok) begin
					cmd.emit_mid = 1'b1;
					state_d      = ST_SET_LO;
				end
			end
			ST_SET_LO: begin
				cmd.set_lo = 1'b1;
				state_d    = ST_SET_IDX;
			end
			ST_SET_IDX: begin
				cmd.set_idx = 1'b1;
				state_d     = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_done) begin
					state_d = status.eot_pend ? ST_EMIT_LAST : ST_IDLE;
				end
			end
			ST_EMIT_LAST: begin
				if (status.emit_ok) begin
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/wbtc_datapath.sv
module wbtc_datapath
	import wbtc_pkg::*;
#(
	parameter int TEXT_LIMIT     = TEXT_LIMIT_DEF,
	parameter int MAX_DOC_CHUNKS = MAX_DOC_CHUNKS_DEF,
	parameter int SIZE_LIMIT     = SIZE_LIMIT_DEF,
	parameter int SPACE_WINDOW   = SPACE_WINDOW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wbtc_in_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wbtc_out_t            out_data,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	input  wbtc_cmd_t            cmd,
	output wbtc_status_t         status
);

	localparam int PW = $clog2(TEXT_LIMIT + 1);
	localparam int ZW = $clog2(SIZE_LIMIT + 1);
	localparam int OW = (ZW > OVL_W) ? ZW : OVL_W;
	localparam int AW = $clog2(SPACE_WINDOW);
	localparam int WW = $clog2(SPACE_WINDOW + 1);
	localparam int CW = ((PW > WW) ? PW : WW) + 1;
	localparam int HW = ((PW > ZW) ? PW : ZW) + 1;
	localparam int NW = $clog2(MAX_DOC_CHUNKS + 1);

	// configuration
	logic [CFG_W-1:0] chunk_size_q;
	logic [OVL_W-1:0] overlap_q;
	logic             quarter_q;

	// per-document state
	logic [PW-1:0]   pos_q;
	logic [PW-1:0]   cb_q;
	logic [PW-1:0]   last_sp_q;
	logic            spv_q;
	logic [AW-1:0]   widx_q;
	logic [NW-1:0]   cnt_q;
	logic [ID_W-1:0] id_q;
	logic            eot_q;

	// chunk / scan
	logic [PW-1:0]   end_q;
	logic [PW-1:0]   lo_q;
	logic [PW-1:0]   addr_q;
	logic [AW-1:0]   rd_idx_q;
	logic            pend_s1;
	logic [PW-1:0]   pos_s1;
	logic            rdata;

	logic            out_valid_q;
	wbtc_out_t       out_q;

	logic [ZW-1:0]   size;
	logic [OW-1:0]   ov;
	logic            room;
	logic            is_sp;
	logic [PW-1:0]   end_in;
	logic [CW-1:0]   lo_a;
	logic [CW-1:0]   lo_w;
	logic [CW-1:0]   lo_d;
	logic [PW-1:0]   back_span;
	logic [CW-1:0]   idx_d;
	logic            addr_lt;
	logic            found;
	logic            scan_done;
	logic [PW-1:0]   nxt_pick;
	logic [PW-1:0]   nxt;
	logic            limit;
	logic            out_room;
	logic            emit;
	logic            load;
	logic            rd_en;

	always_comb begin
		if (chunk_size_q == '0) begin
			size = ZW'(1);
		end else if (int'(chunk_size_q) > SIZE_LIMIT) begin
			size = ZW'(SIZE_LIMIT);
		end else begin
			size = ZW'(chunk_size_q);
		end
	end

	assign ov    = quarter_q ? OW'(size >> QUARTER_SHIFT) : OW'(overlap_q);
	assign room  = (pos_q != PW'(TEXT_LIMIT));
	assign is_sp = (in_data.text_byte == SPACE_CODE);

	// chunk end if this byte completes the window
	assign end_in = is_sp ? pos_q :
		((spv_q && (last_sp_q > cb_q)) ? last_sp_q : pos_q);

	// lower scan bound: end - overlap, kept inside the space window
	assign lo_a = (CW'(end_q) > CW'(ov)) ? (CW'(end_q) - CW'(ov)) : '0;
	assign lo_w = (CW'(pos_q) > CW'(SPACE_WINDOW)) ?
		(CW'(pos_q) - CW'(SPACE_WINDOW)) : '0;
	assign lo_d = (lo_a > lo_w) ? lo_a : lo_w;

	// window slot of lo_q, counted back from the write slot
	assign back_span = pos_q - lo_q;
	assign idx_d = (CW'(widx_q) >= CW'(back_span)) ? (CW'(widx_q) - CW'(back_span)) :
		(CW'(widx_q) + CW'(SPACE_WINDOW) - CW'(back_span));

	assign addr_lt   = (addr_q < end_q);
	assign found     = pend_s1 && rdata;
	assign scan_done = found || (!pend_s1 && !addr_lt);
	assign nxt_pick  = found ? pos_s1 : end_q;
	assign nxt       = (nxt_pick <= cb_q) ? end_q : nxt_pick;
	assign rd_en     = cmd.scan_step && !scan_done && addr_lt;

	assign limit    = (cnt_q >= NW'(MAX_DOC_CHUNKS));
	assign out_room = !out_valid_q || out_ready;
	assign emit     = cmd.emit_mid || cmd.emit_last;
	assign load     = emit && !limit;

	assign status.hit_in    = room && ((HW'(cb_q) + HW'(size)) == HW'(pos_q));
	assign status.eot_in    = in_data.end_of_text;
	assign status.eot_pend  = eot_q;
	assign status.emit_ok   = limit || out_room;
	assign status.scan_done = scan_done;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	wbtc_ram #(
		.WIDTH(1),
		.DEPTH(SPACE_WINDOW)
	) u_flags (
		.clk  (clk),
		.we   (cmd.accept && room),
		.waddr(widx_q),
		.wdata(is_sp),
		.re   (rd_en),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= CHUNK_SIZE_RST;
			overlap_q    <= OVERLAP_RST;
			quarter_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CHUNK_SIZE: chunk_size_q <= cfg_wr_data;
				REG_OVERLAP:    overlap_q    <= cfg_wr_data[OVL_W-1:0];
				REG_QUARTER:    quarter_q    <= cfg_wr_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			cb_q        <= '0;
			spv_q       <= 1'b0;
			widx_q      <= '0;
			cnt_q       <= '0;
			id_q        <= ID_W'(1);
			eot_q       <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				eot_q <= in_data.end_of_text;
				if (room) begin
					pos_q  <= pos_q + 1'b1;
					widx_q <= (widx_q == AW'(SPACE_WINDOW - 1)) ? '0 : widx_q + 1'b1;
					if (is_sp) begin
						spv_q <= 1'b1;
					end
				end
			end
			if (cmd.set_idx) begin
				pend_s1 <= 1'b0;
			end
			if (cmd.scan_step) begin
				if (scan_done) begin
					cb_q    <= nxt;
					pend_s1 <= 1'b0;
				end else begin
					pend_s1 <= addr_lt;
				end
			end
			if (load) begin
				id_q <= (id_q == '1) ? ID_W'(1) : id_q + 1'b1;
			end
			if (load && !cmd.emit_last) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// document done: per-document state back to reset
			if (cmd.emit_last) begin
				pos_q  <= '0;
				cb_q   <= '0;
				spv_q  <= 1'b0;
				widx_q <= '0;
				cnt_q  <= '0;
				eot_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && room) begin
			end_q <= end_in;
			if (is_sp) begin
				last_sp_q <= pos_q;
			end
		end
		if (cmd.set_lo) begin
			lo_q <= PW'(lo_d);
		end
		if (cmd.set_idx) begin
			addr_q   <= lo_q;
			rd_idx_q <= AW'(idx_d);
		end
		if (rd_en) begin
			pos_s1   <= addr_q;
			addr_q   <= addr_q + 1'b1;
			rd_idx_q <= (rd_idx_q == AW'(SPACE_WINDOW - 1)) ? '0 : rd_idx_q + 1'b1;
		end
		if (load) begin
			out_q.chunk_seq    <= id_q;
			out_q.chunk_start  <= POS_OUT_W'(cb_q);
			out_q.chunk_end    <= cmd.emit_last ? POS_OUT_W'(pos_q) : POS_OUT_W'(end_q);
			out_q.first_in_doc <= (cnt_q == '0);
			out_q.last_chunk   <= cmd.emit_last;
		end
	end

`ifndef SYNTHESIS
	a_start_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && scan_done) |=> (cb_q > $past(cb_q)))
		else $error("chunk start did not advance");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (pos_s1 < end_q))
		else $error("scan read past chunk end");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(MAX_DOC_CHUNKS))
		else $error("chunk count over limit");

	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		id_q != '0)
		else $error("chunk id is zero");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (limit || out_room))
		else $error("chunk emitted over a held word");
`endif

endmodule

>>> rtl/word_boundary_text_chunker.sv
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    in_data   (text_byte, end_of_text)
// out      source     out_valid / out_ready  out_data  (chunk_seq .. last_chunk)
// cfg      sink       cfg_wr_en              cfg_index, cfg_wr_data
//
// A byte that does not close a chunk window leaves the block ready for more.
// A byte that closes a window runs accept, emit, the set_lo and set_idx setup
// states, then the overlap scan reads one space flag per cycle from the
// flag RAM (single read port), stopping at the first space found; a scan that
// finds none ends once its last read has been checked.
// An end_of_text word adds an emit_last step for the final chunk.
// Reset (arst_n low) restores registers and clears per-document state; no
// clearing pass over the flag RAM is needed.
// A held output word stalls the next emission, and input behind it; bytes that
// close no window are taken while it waits.
module word_boundary_text_chunker
	import wbtc_pkg::*;
#(
	parameter int TEXT_LIMIT     = TEXT_LIMIT_DEF,
	parameter int MAX_DOC_CHUNKS = MAX_DOC_CHUNKS_DEF,
	parameter int SIZE_LIMIT     = SIZE_LIMIT_DEF,
	parameter int SPACE_WINDOW   = SPACE_WINDOW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  wbtc_in_t             in_data,

	output logic                 out_valid,
	input  logic                 out_ready,
	output wbtc_out_t            out_data,

	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wr_data
);

	// controller sequences accept -> emit -> scan setup -> scan -> final emit;
	// datapath owns positions, the space flag RAM and the output register
	wbtc_cmd_t    cmd;
	wbtc_status_t status;

	wbtc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	wbtc_datapath #(
		.TEXT_LIMIT    (TEXT_LIMIT),
		.MAX_DOC_CHUNKS(MAX_DOC_CHUNKS),
		.SIZE_LIMIT    (SIZE_LIMIT),
		.SPACE_WINDOW  (SPACE_WINDOW)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.cmd        (cmd),
		.status     (status)
	);

endmodule

>>> bench/tb_word_boundary_text_chunker.sv
module tb_word_boundary_text_chunker;
	import wbtc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// A byte that closes a window can keep the block busy for emit, the set_lo and
	// set_idx setup states and up to 511 overlap scan reads after its chunk word has left.
	localparam int WIND_DOWN   = 600;
	// Longest correct silence: receiver hold plus a full scan plus a register
	// pause, with plenty of margin.
	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_CYCLES = 500;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	wbtc_in_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	wbtc_out_t            out_data;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_CHUNK_SIZE;
	logic [CFG_W-1:0]     cfg_wr_data = '0;

	word_boundary_text_chunker DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------
	wbtc_in_t  text_q[$];           // bytes waiting to be offered
	wbtc_out_t expected_chunks[$];  // chunk words the block still owes us

	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int mismatches   = 0;
	int bytes_taken  = 0;
	int docs_taken   = 0;
	int chunks_seen  = 0;
	int quiet_cycles = 0;
	int stall_left   = 0;
	bit stall_done   = 1'b0;
	bit hold_armed   = 1'b0;

	// shadow of the block's registers
	logic [CFG_W-1:0] size_reg    = CHUNK_SIZE_RST;
	logic [OVL_W-1:0] overlap_reg = OVERLAP_RST;
	logic             quarter_reg = 1'b0;

	// shadow of the per-document tracking and the running id
	int unsigned doc_pos    = 0;
	int unsigned win_begin  = 0;
	int unsigned last_space = 0;
	bit          space_seen = 1'b0;
	bit          space_map[SPACE_WINDOW_DEF];
	int unsigned next_id    = 1;
	int unsigned doc_chunks = 0;

	// directed text: spaces at 1 and 4 make the overlap scan land on the
	// current start with size 8 / overlap 4, so the start must jump to the end
	logic [7:0] demo_text[18] = '{"a", " ", "b", "b", " ", "c", "c", "c", "c",
		8'h00, 8'hFF, "d", "d", " ", " ", "e", "e", "e"};
	logic [7:0] blank_text[5] = '{" ", " ", " ", " ", 8'h00};

	// ------------------------------------------------------------------
	// Chunk boundary predictor
	// ------------------------------------------------------------------
	function automatic void new_document();
		doc_pos    = 0;
		win_begin  = 0;
		last_space = 0;
		space_seen = 1'b0;
		doc_chunks = 0;
		foreach (space_map[i]) space_map[i] = 1'b0;
	endfunction

	// positions at or past the write point, or fallen out of the window,
	// never count as spaces
	function automatic bit space_before(input int unsigned q);
		if (q >= doc_pos) return 1'b0;
		if (doc_pos - q > SPACE_WINDOW_DEF) return 1'b0;
		return space_map[q % SPACE_WINDOW_DEF];
	endfunction

	// chunks past the per-document cap are swallowed and burn no id
	function automatic void log_chunk(input int unsigned lo, input int unsigned hi,
			input bit closing);
		wbtc_out_t c;
		if (doc_chunks >= MAX_DOC_CHUNKS_DEF) return;
		c.chunk_seq    = ID_W'(next_id);
		c.chunk_start  = POS_OUT_W'(lo);
		c.chunk_end    = POS_OUT_W'(hi);
		c.first_in_doc = (doc_chunks == 0);
		c.last_chunk   = closing;
		expected_chunks.push_back(c);
		next_id = (next_id >= 32'hFFFF) ? 1 : next_id + 1;
		doc_chunks++;
	endfunction

	function automatic void track_byte(input wbtc_in_t w);
		int unsigned size, p, span_end, ovl, q, nxt;
		size = size_reg;
		if (size < 1) size = 1;
		if (size > SIZE_LIMIT_DEF) size = SIZE_LIMIT_DEF;
		// bytes beyond the text limit are dropped, but end_of_text still counts
		if (doc_pos < TEXT_LIMIT_DEF) begin
			p = doc_pos;
			space_map[p % SPACE_WINDOW_DEF] = (w.text_byte == SPACE_CODE);
			if (w.text_byte == SPACE_CODE) begin
				last_space = p;
				space_seen = 1'b1;
			end
			doc_pos = p + 1;
			// byte start+size has arrived: the window is fully known
			if (win_begin + size == p) begin
				span_end = (space_seen && last_space > win_begin) ? last_space : p;
				ovl = quarter_reg ? (size >> QUARTER_SHIFT) : overlap_reg;
				nxt = span_end;
				log_chunk(win_begin, span_end, 1'b0);
				if (ovl > 0) begin
					q = (span_end > ovl) ? span_end - ovl : 0;
					while (q < span_end && !space_before(q)) q++;
					nxt = q;
				end
				// start must always move forward
				if (nxt <= win_begin) nxt = span_end;
				win_begin = nxt;
			end
		end
		if (w.end_of_text) begin
			log_chunk(win_begin, doc_pos, 1'b1);
			new_document();
		end
	endfunction

	function automatic void check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	function automatic void add_word(input logic [7:0] b, input logic eot);
		wbtc_in_t w;
		w.text_byte   = b;
		w.end_of_text = eot;
		text_q.push_back(w);
	endfunction

	// wild documents use any byte value, otherwise lowercase prose
	function automatic void add_doc(input int len, input int space_pct, input bit wild);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < space_pct) b = SPACE_CODE;
			else if (wild) b = 8'($urandom_range(255));
			else b = 8'("a" + $urandom_range(25));
			add_word(b, i == len - 1);
		end
	endfunction

	// mostly readable text, some of it short stubs; the rest is binary noise and space runs
	function automatic void add_random_docs(input int budget, input int max_len);
		int len, kind;
		while (budget > 0) begin
			kind = $urandom_range(99);
			len  = (kind < 10) ? 1 + $urandom_range(2) : 1 + $urandom_range(max_len - 1);
			if (len > budget) len = budget;
			if (kind < 80) add_doc(len, 8 + $urandom_range(17), 1'b0);
			else if (kind < 90) add_doc(len, $urandom_range(3), 1'b1);
			else add_doc(len, 70 + $urandom_range(30), 1'b1);
			budget -= len;
		end
	endfunction

	// registers are only touched while the block is idle
	task automatic set_regs(input int size, input int ovl, input bit quarter);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= REG_CHUNK_SIZE;
		cfg_wr_data <= CFG_W'(size);
		@(posedge clk);
		cfg_index   <= REG_OVERLAP;
		cfg_wr_data <= CFG_W'(ovl);
		@(posedge clk);
		cfg_index   <= REG_QUARTER;
		cfg_wr_data <= CFG_W'(quarter);
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		size_reg    = CFG_W'(size);
		overlap_reg = OVL_W'(ovl);
		quarter_reg = quarter;
	endtask

	// everything offered, taken and answered, then let a trailing scan finish
	task automatic settle();
		do @(negedge clk);
		while (text_q.size() != 0 || in_valid || expected_chunks.size() != 0);
		repeat (WIND_DOWN) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Sender: keeps a word steady until it is taken
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else if (!in_valid || in_ready) begin
			if (text_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				in_valid <= 1'b1;
				in_data  <= text_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random backpressure plus one long hold while input is still
	// flowing, so the block fills up and has to refuse bytes
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
			stall_done <= 1'b0;
		end else if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!stall_done && hold_armed && text_q.size() > 150) begin
			out_ready  <= 1'b0;
			stall_left <= HOLD_CYCLES;
			stall_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on every byte taken, check every chunk word delivered
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		wbtc_out_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				track_byte(in_data);
				bytes_taken <= bytes_taken + 1;
				if (in_data.end_of_text) docs_taken <= docs_taken + 1;
			end
			if (out_valid && out_ready) begin
				chunks_seen <= chunks_seen + 1;
				if (expected_chunks.size() == 0) begin
					$display("%0t: chunk word with nothing expected, expected none actual %p",
						$time, out_data);
					mismatches++;
				end else begin
					want = expected_chunks.pop_front();
					check_field("chunk_seq", want.chunk_seq, out_data.chunk_seq);
					check_field("chunk_start", want.chunk_start, out_data.chunk_start);
					check_field("chunk_end", want.chunk_end, out_data.chunk_end);
					check_field("first_in_doc", want.first_in_doc, out_data.first_in_doc);
					check_field("last_chunk", want.last_chunk, out_data.last_chunk);
				end
			end
		end
	end

	// watchdog: too long without a word moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d chunk words outstanding",
					$time, QUIET_LIMIT, expected_chunks.size());
				$display("FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		new_document();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender mostly busy, receiver often stalling
		send_gap_pct = 6;
		recv_gap_pct = 50;

		// directed: a lone 0xFF document, the start-not-advancing text, a
		// document made of spaces ending in a zero byte
		set_regs(8, 4, 1'b0);
		add_word(8'hFF, 1'b1);
		foreach (demo_text[i]) add_word(demo_text[i], i == 17);
		foreach (blank_text[i]) add_word(blank_text[i], i == 4);
		settle();

		set_regs(128, 32, 1'b0);
		add_random_docs(300, 300);
		settle();
		set_regs(16, 511, 1'b0);
		add_random_docs(200, 80);
		settle();
		// size 0 behaves as 1, no overlap
		set_regs(0, 0, 1'b0);
		add_random_docs(100, 40);
		settle();

		// sender gappy, receiver mostly ready
		send_gap_pct = 50;
		recv_gap_pct = 6;
		// oversize request clamps to the largest window, deepest overlap scan
		set_regs(1023, 511, 1'b0);
		add_random_docs(400, 1500);
		settle();
		set_regs(40, 0, 1'b1);
		add_random_docs(200, 150);
		settle();
		set_regs(1, 511, 1'b0);
		add_random_docs(60, 30);
		settle();

		// full speed on both sides
		send_gap_pct = 0;
		recv_gap_pct = 0;
		set_regs(7, 3, 1'b1);
		add_random_docs(250, 40);
		settle();

		// one chunk per byte runs into the per-document chunk cap; the
		// receiver holds off meanwhile so the block backs up its input
		set_regs(1, 0, 1'b0);
		add_doc(MAX_DOC_CHUNKS_DEF + 28, 15, 1'b1);
		hold_armed = 1'b1;
		settle();

		$display("Covered %0d bytes in %0d documents and %0d checked chunk words,",
			bytes_taken, docs_taken, chunks_seen);
		$display("across nine register settings, clamped sizes and the per-document chunk cap.");
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
